// ===== hdl/ssf_pkg.sv =====
package ssf_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 2;
  localparam int WEIGHT_W   = 16;
  localparam int NOISE_W    = 16;

  localparam int ERR_W     = 17;
  localparam int GAIN_W    = 17;
  localparam int DEN_W     = NOISE_W + 9;
  localparam int REM_W     = DEN_W + 1;
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int FRAC_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KALMAN = 2'd2;

  localparam logic [MODE_W-1:0]   MODE_RST   = MODE_EXP;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd13107;
  localparam logic [NOISE_W-1:0]  NOISE_RST  = 16'd0;

  localparam logic [ERR_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [ERR_W-1:0] SEED_Q16 = 17'd6554;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV     = 6'b000010,
    ST_MUL_ERR = 6'b000100,
    ST_MUL_OUT = 6'b001000,
    ST_ROUND   = 6'b010000,
    ST_WRITE   = 6'b100000
  } state_t;

endpackage

// ===== hdl/selectable_sensor_smoothing_filter_top.sv =====
// Channel  | Ports                          | Transfer when
// ---------+--------------------------------+--------------------------
// input    | in_valid, in_ready, in_sample  | in_valid and in_ready
// result   | out_valid, out_ready, out_smoothed | out_valid and out_ready
// config   | cfg_wr_en, cfg_index, cfg_wdata | cfg_wr_en high
//
// An item goes straight to the write state in pass-through and through one multiply and the
// rounding step in exponential mode. In Kalman mode the 17-step restoring divider forms the
// gain, followed by two passes through the single shared 18-bit by max(18, SAMPLE_BITS+1) multiplier.
// Reset is synchronous and active low; it loads the register defaults and clears state.
// A finished result waits in the output register while the next item is taken; a
// second result waits in the write state until the output register is free.
module selectable_sensor_smoothing_filter_top #(
  parameter int SAMPLE_BITS = ssf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_smoothed,
  input  logic                               cfg_wr_en,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import ssf_pkg::*;

  localparam int DW = SAMPLE_BITS + 1;
  localparam int BW = (DW > GAIN_W + 1) ? DW : GAIN_W + 1;
  localparam int PW = GAIN_W + 1 + BW;
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  state_t                         state_r, state_nxt;
  logic [MODE_W-1:0]              mode_r, mode_nxt;
  logic [WEIGHT_W-1:0]            weight_r, weight_nxt;
  logic [NOISE_W-1:0]             noise_r, noise_nxt;
  logic signed [SAMPLE_BITS-1:0]  prev_r, prev_nxt;
  logic [ERR_W-1:0]               err_r, err_nxt;
  logic                           primed_r, primed_nxt;
  logic                           kal_r, kal_nxt;
  logic signed [DW-1:0]           delta_r, delta_nxt;
  logic [GAIN_W-1:0]              gain_r, gain_nxt;
  logic [REM_W-1:0]               rem_r, rem_nxt;
  logic [DEN_W-1:0]               den_r, den_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic signed [PW-1:0]           prod_r, prod_nxt;
  logic signed [SAMPLE_BITS-1:0]  res_r, res_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic                           accept;
  logic                           cfg_hit;
  logic [MODE_W-1:0]              cfg_mode;
  logic                           rem_ge;
  logic [REM_W-1:0]               rem_sub;
  logic signed [GAIN_W:0]         mul_a;
  logic signed [BW-1:0]           mul_b;
  logic signed [PW-1:0]           mul_p;
  logic signed [PW-1:0]           rnd;
  logic signed [PW-1:0]           sum;
  logic [PW-SAMPLE_BITS:0]        sum_hi;
  logic signed [SAMPLE_BITS-1:0]  sat;

  assign in_ready     = (state_r == ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_smoothed = out_r;

  always_comb begin
    cfg_hit  = 1'b0;
    cfg_mode = mode_r;
    unique case (cfg_index)
      REG_MODE: begin
        cfg_hit  = 1'b1;
        cfg_mode = cfg_wdata[MODE_W-1:0];
      end
      REG_WEIGHT: cfg_hit = 1'b1;
      REG_NOISE:  cfg_hit = 1'b1;
      default:    cfg_hit = 1'b0;
    endcase
  end

  assign rem_ge  = (rem_r >= {1'b0, den_r});
  assign rem_sub = rem_ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_comb begin
    if (state_r == ST_MUL_ERR) begin
      mul_a = $signed({1'b0, ONE_Q16 - gain_r});
      mul_b = $signed(BW'(err_r));
    end else begin
      mul_a = $signed({1'b0, gain_r});
      mul_b = BW'(delta_r);
    end
  end

  assign mul_p  = PW'(mul_a * mul_b);
  assign rnd    = (prod_r + ROUND_HALF) >>> FRAC_W;
  assign sum    = rnd + PW'(prev_r);
  assign sum_hi = sum[PW-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&sum_hi) || !(|sum_hi)) begin
      sat = sum[SAMPLE_BITS-1:0];
    end else if (sum[PW-1]) begin
      sat = SMIN;
    end else begin
      sat = SMAX;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    weight_nxt    = weight_r;
    noise_nxt     = noise_r;
    prev_nxt      = prev_r;
    err_nxt       = err_r;
    primed_nxt    = primed_r;
    kal_nxt       = kal_r;
    delta_nxt     = delta_r;
    gain_nxt      = gain_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_wr_en && cfg_hit) begin
      unique case (cfg_index)
        REG_MODE:   mode_nxt   = cfg_wdata[MODE_W-1:0];
        REG_WEIGHT: weight_nxt = cfg_wdata[WEIGHT_W-1:0];
        REG_NOISE:  noise_nxt  = cfg_wdata[NOISE_W-1:0];
        default:    mode_nxt   = mode_r;
      endcase
      err_nxt = (cfg_mode == MODE_KALMAN) ? ONE_Q16 : '0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          delta_nxt = DW'(in_sample) - DW'(prev_r);
          kal_nxt   = (mode_r == MODE_KALMAN);
          res_nxt   = in_sample;
          if (!primed_r) begin
            primed_nxt = 1'b1;
            prev_nxt   = in_sample;
            state_nxt  = ST_WRITE;
          end else if (mode_r == MODE_EXP) begin
            gain_nxt  = GAIN_W'(weight_r);
            state_nxt = ST_MUL_OUT;
          end else if (mode_r == MODE_KALMAN) begin
            if (err_r == '0) begin
              err_nxt   = SEED_Q16;
              prev_nxt  = in_sample;
              state_nxt = ST_WRITE;
            end else begin
              rem_nxt   = REM_W'(err_r);
              den_nxt   = DEN_W'(err_r) + {1'b0, noise_r, 8'h00};
              gain_nxt  = '0;
              cnt_nxt   = CNT_W'(DIV_STEPS - 1);
              state_nxt = ST_DIV;
            end
          end else begin
            prev_nxt  = in_sample;
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_DIV: begin
        gain_nxt = {gain_r[GAIN_W-2:0], rem_ge};
        rem_nxt  = {rem_sub[REM_W-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MUL_ERR;
        end
      end
      ST_MUL_ERR: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_OUT;
      end
      ST_MUL_OUT: begin
        if (kal_r) begin
          err_nxt = prod_r[FRAC_W+ERR_W-1:FRAC_W];
        end
        prod_nxt  = mul_p;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        res_nxt   = sat;
        prev_nxt  = sat;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_RST;
      weight_r    <= WEIGHT_RST;
      noise_r     <= NOISE_RST;
      prev_r      <= '0;
      err_r       <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      weight_r    <= weight_nxt;
      noise_r     <= noise_nxt;
      prev_r      <= prev_nxt;
      err_r       <= err_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kal_r   <= kal_nxt;
    delta_r <= delta_nxt;
    gain_r  <= gain_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (den_r != '0))
    else $error("Divider runs with a zero denominator.");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < {den_r, 1'b0}))
    else $error("Divider remainder left its range.");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_ERR) |-> (gain_r <= ONE_Q16))
    else $error("Kalman gain exceeds one.");

  a_result_primed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> primed_r)
    else $error("Result shown before any sample was taken.");

  a_write_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && (!out_valid_r || out_ready)) |=> (out_valid_r && out_r == $past(res_r)))
    else $error("Finished result did not reach the output register.");

endmodule

// ===== bench/smoothed_sample_checker.sv =====
module smoothed_sample_checker #(
  parameter int SAMPLE_BITS = ssf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SAMPLE_BITS-1:0] out_smoothed,
  input  logic                          cfg_wr_en,
  input  logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                            pending,
  output int                            mismatches,
  output int                            results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import ssf_pkg::*;

  logic [MODE_W-1:0]             mode_r;
  logic [WEIGHT_W-1:0]           weight_r;
  logic [NOISE_W-1:0]            noise_r;
  logic signed [SAMPLE_BITS-1:0] last_out;
  logic [ERR_W-1:0]              err_est;
  logic                          seen_first;

  logic signed [SAMPLE_BITS-1:0] smoothed_queue[$];

  function automatic longint clamp_sample(input longint v);
    longint lo;
    longint hi;
    lo = -(longint'(1) << (SAMPLE_BITS - 1));
    hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
      input logic signed [SAMPLE_BITS-1:0] raw);
    longint          x;
    longint          p;
    longint          acc;
    longint          y;
    longint unsigned den;
    longint unsigned gain;
    x = raw;
    p = last_out;
    if (!seen_first) begin
      y = x;
      seen_first = 1'b1;
    end else if (mode_r == MODE_EXP) begin
      acc = x * longint'(weight_r) + p * (longint'(ONE_Q16) - longint'(weight_r)) + 32768;
      y = clamp_sample(acc >>> 16);
    end else if (mode_r == MODE_KALMAN) begin
      if (err_est == '0) begin
        err_est = SEED_Q16;
        y = x;
      end else begin
        den  = longint'(err_est) + (longint'(noise_r) << 8);
        gain = (longint'(err_est) << 16) / den;
        if (gain > longint'(ONE_Q16)) gain = longint'(ONE_Q16);
        err_est = ERR_W'(((longint'(ONE_Q16) - gain) * longint'(err_est)) >> 16);
        acc = longint'(gain) * (x - p) + 32768;
        y = clamp_sample(p + (acc >>> 16));
      end
    end else begin
      y = x;
    end
    last_out = SAMPLE_BITS'(y);
    return last_out;
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    logic                          reload;
    if (!rst_n) begin
      mode_r     = MODE_RST;
      weight_r   = WEIGHT_RST;
      noise_r    = NOISE_RST;
      last_out   = '0;
      err_est    = '0;
      seen_first = 1'b0;
      smoothed_queue.delete();
    end else begin
      if (cfg_wr_en) begin
        reload = 1'b1;
        case (cfg_index)
          REG_MODE:   mode_r = cfg_wdata[MODE_W-1:0];
          REG_WEIGHT: weight_r = cfg_wdata[WEIGHT_W-1:0];
          REG_NOISE:  noise_r = cfg_wdata[NOISE_W-1:0];
          default:    reload = 1'b0;
        endcase
        if (reload) err_est = (mode_r == MODE_KALMAN) ? ONE_Q16 : '0;
      end
      if (out_valid && out_ready) begin
        if (smoothed_queue.size() == 0) begin
          $error("smoothed: no transfer expected, got %0d", out_smoothed);
          mismatches++;
        end else begin
          want = smoothed_queue.pop_front();
          results_checked++;
          if (out_smoothed !== want) begin
            $error("smoothed: expected %0d, got %0d", want, out_smoothed);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) smoothed_queue.push_back(filter_sample(in_sample));
    end
    pending = smoothed_queue.size();
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssf_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX   = (1 << (SB - 1)) - 1;
  localparam int SAMPLE_MIN   = -(1 << (SB - 1));
  localparam int RANDOM_ITEMS = 1550;

  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [SB-1:0]  in_sample;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [SB-1:0]  out_smoothed;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int pending;
  int mismatches;
  int results_checked;
  int samples_sent = 0;
  int settings_used = 0;
  int ready_hold = 0;
  int signal_level = 0;
  bit steady_flow = 1'b0;

  selectable_sensor_smoothing_filter_top #(.SAMPLE_BITS(SB)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_smoothed (out_smoothed),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  smoothed_sample_checker #(.SAMPLE_BITS(SB)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_smoothed    (out_smoothed),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .pending         (pending),
    .mismatches      (mismatches),
    .results_checked (results_checked)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    int pick;
    if (steady_flow) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 5);
      end else if (pick < 92) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(10, 50);
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    if (steady_flow) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SB-1:0] draw_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return SB'($urandom);
    if (pick < 28) begin
      case ($urandom_range(0, 3))
        0:       return SB'(SAMPLE_MIN);
        1:       return SB'(SAMPLE_MAX);
        2:       return '0;
        default: return '1;
      endcase
    end
    if (pick < 32) signal_level = SAMPLE_MIN + int'($urandom_range(0, SAMPLE_MAX - SAMPLE_MIN));
    signal_level = signal_level + int'($urandom_range(0, 512)) - 256;
    if (signal_level > SAMPLE_MAX) signal_level = SAMPLE_MAX;
    if (signal_level < SAMPLE_MIN) signal_level = SAMPLE_MIN;
    return SB'(signal_level);
  endfunction

  task automatic push_sample(input logic signed [SB-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  // Holds off the sender until every outstanding result has been transferred.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] which, input logic [MODE_W-1:0] mode_val,
                              input logic [WEIGHT_W-1:0] weight_val,
                              input logic [NOISE_W-1:0] noise_val);
    drain();
    for (int i = 0; i < 4; i++) begin
      if (which[i]) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        case (CFG_IDX_W'(i))
          REG_MODE:   cfg_wdata <= CFG_DATA_W'(mode_val);
          REG_WEIGHT: cfg_wdata <= CFG_DATA_W'(weight_val);
          REG_NOISE:  cfg_wdata <= CFG_DATA_W'(noise_val);
          default:    cfg_wdata <= CFG_DATA_W'($urandom);
        endcase
        @(posedge clk);
      end
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [MODE_W-1:0]   mode_pick;
    logic [WEIGHT_W-1:0] weight_pick;
    logic [NOISE_W-1:0]  noise_pick;
    logic [3:0]          which;
    int                  pick;
    int                  batch;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the first sample passes through, then exponential smoothing.
    push_sample(16'sh1234);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh0000);
    push_sample(16'shFFFF);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);

    program_regs(4'b0001, MODE_PASS, WEIGHT_RST, NOISE_RST);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);

    program_regs(4'b0001, MODE_UNUSED, WEIGHT_RST, NOISE_RST);
    push_sample(16'sh0100);

    program_regs(4'b0011, MODE_EXP, 16'hFFFF, NOISE_RST);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    program_regs(4'b0010, MODE_EXP, 16'h0001, NOISE_RST);
    push_sample(16'sh8000);
    push_sample(16'sh4000);
    program_regs(4'b0010, MODE_EXP, 16'h0000, NOISE_RST);
    push_sample(16'sh7FFF);

    // With no measurement noise the gain is one and the estimate collapses and reseeds.
    program_regs(4'b0101, MODE_KALMAN, WEIGHT_RST, 16'h0000);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh0200);
    program_regs(4'b0100, MODE_KALMAN, WEIGHT_RST, 16'hFFFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    program_regs(4'b1100, MODE_KALMAN, WEIGHT_RST, 16'h0100);
    push_sample(16'sh1000);
    push_sample(16'shF000);
    push_sample(16'sh1000);

    while (samples_sent < 25 + RANDOM_ITEMS) begin
      steady_flow <= ($urandom_range(0, 6) == 0);

      pick = $urandom_range(0, 9);
      if (pick == 0) mode_pick = MODE_PASS;
      else if (pick < 5) mode_pick = MODE_EXP;
      else if (pick < 9) mode_pick = MODE_KALMAN;
      else mode_pick = MODE_UNUSED;

      pick = $urandom_range(0, 99);
      if (pick < 20) weight_pick = '1;
      else if (pick < 30) weight_pick = 16'h0001;
      else if (pick < 35) weight_pick = '0;
      else weight_pick = WEIGHT_W'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 20) noise_pick = '0;
      else if (pick < 30) noise_pick = '1;
      else if (pick < 70) noise_pick = NOISE_W'($urandom_range(1, 1024));
      else noise_pick = NOISE_W'($urandom);

      which[0] = ($urandom_range(0, 9) < 7);
      which[1] = ($urandom_range(0, 9) < 7);
      which[2] = ($urandom_range(0, 9) < 7);
      which[3] = ($urandom_range(0, 19) < 3);
      if (which == '0) which[0] = 1'b1;
      program_regs(which, mode_pick, weight_pick, noise_pick);

      batch = $urandom_range(20, 120);
      repeat (batch) begin
        if ($urandom_range(0, 59) == 0) drain();
        push_sample(draw_sample());
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Run covered %0d samples over %0d register settings in pass-through,",
             samples_sent, settings_used);
    $display("exponential and Kalman modes; %0d smoothed results compared.", results_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("** selectable_sensor_smoothing_filter_top: PASSED **");
    end else begin
      $display("** selectable_sensor_smoothing_filter_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("** selectable_sensor_smoothing_filter_top: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ssf_pkg.sv
hdl/selectable_sensor_smoothing_filter_top.sv
bench/smoothed_sample_checker.sv
bench/testbench.sv
